FILE: hw/rtl/esc_pkg.sv
package esc_pkg;

	// Calendar constants: the epoch year, then periods in seconds.
	localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
	localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
	localparam logic [31:0] SECS_PER_YEAR  = 32'd31536000;
	localparam logic [31:0] SECS_PER_LYEAR = 32'd31622400;
	localparam logic [31:0] SECS_PER_HOUR  = 32'd3600;
	localparam logic [31:0] SECS_PER_MIN   = 32'd60;

	// Month index of December, past which the month walk never goes.
	localparam logic [3:0] LAST_MONTH = 4'd11;

	// Length of a month in seconds; February gains a day in a leap year.
	function automatic logic [31:0] month_secs(input logic [3:0] mon, input logic leap);
		logic [31:0] secs;
		case (mon)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: secs = 32'd2678400;
			4'd3, 4'd5, 4'd8, 4'd10: secs = 32'd2592000;
			4'd1: secs = leap ? 32'd2505600 : 32'd2419200;
			default: secs = 32'd2678400;
		endcase
		return secs;
	endfunction

endpackage

FILE: hw/rtl/epoch_seconds_to_calendar_core.sv
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into year, month, day,
// hour, minute and second, with every year divisible by four taken as a leap year
// (2100 included). One 32-bit compare-and-subtract unit is shared by all steps: it
// strips whole years, then months, days, hours and minutes off the remainder, one
// period per cycle, and what is left is the second. The input is not ready while a
// conversion runs. The result waits in an output register, so a new request is taken
// as soon as the previous result has been moved there.
module epoch_seconds_to_calendar_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // epoch_seconds[31:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // year[11:0], month[15:12], day[20:16], hour[25:21],
	                               // minute[31:26], second[37:32], zero[39:38]
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_YEAR   = 3'd1;
	localparam logic [2:0] ST_MONTH  = 3'd2;
	localparam logic [2:0] ST_DAY    = 3'd3;
	localparam logic [2:0] ST_HOUR   = 3'd4;
	localparam logic [2:0] ST_MINUTE = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0]  state_q;
	logic [31:0] rem_q;
	logic [11:0] year_q;
	logic [3:0]  mon_q;
	logic [4:0]  day_q;
	logic [4:0]  hour_q;
	logic [5:0]  min_q;
	logic        out_valid_q;
	logic [39:0] out_data_q;

	logic [31:0] sub;
	logic        ge;
	logic [31:0] diff;
	logic        leap;
	logic        out_free;

	assign leap     = (year_q[1:0] == 2'b00);
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Period subtracted in the current step.
	always_comb begin
		case (state_q)
			ST_YEAR:   sub = leap ? esc_pkg::SECS_PER_LYEAR : esc_pkg::SECS_PER_YEAR;
			ST_MONTH:  sub = esc_pkg::month_secs(mon_q, leap);
			ST_DAY:    sub = esc_pkg::SECS_PER_DAY;
			ST_HOUR:   sub = esc_pkg::SECS_PER_HOUR;
			ST_MINUTE: sub = esc_pkg::SECS_PER_MIN;
			default:   sub = esc_pkg::SECS_PER_MIN;
		endcase
	end

	// The shared compare-and-subtract unit.
	assign ge   = (rem_q >= sub);
	assign diff = rem_q - sub;

	// Sequencer and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_YEAR;
					end
				end
				ST_YEAR: begin
					if (!ge) begin
						state_q <= ST_MONTH;
					end
				end
				ST_MONTH: begin
					if (!ge || mon_q == esc_pkg::LAST_MONTH) begin
						state_q <= ST_DAY;
					end
				end
				ST_DAY: begin
					if (!ge) begin
						state_q <= ST_HOUR;
					end
				end
				ST_HOUR: begin
					if (!ge) begin
						state_q <= ST_MINUTE;
					end
				end
				ST_MINUTE: begin
					if (!ge) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Remainder and field counters; each step either subtracts and counts or moves on.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rem_q  <= s_tdata;
				year_q <= esc_pkg::EPOCH_YEAR;
				mon_q  <= 4'd0;
				day_q  <= 5'd0;
				hour_q <= 5'd0;
				min_q  <= 6'd0;
			end
			ST_YEAR: begin
				if (ge) begin
					rem_q  <= diff;
					year_q <= year_q + 12'd1;
				end
			end
			ST_MONTH: begin
				if (ge && mon_q != esc_pkg::LAST_MONTH) begin
					rem_q <= diff;
					mon_q <= mon_q + 4'd1;
				end
			end
			ST_DAY: begin
				if (ge) begin
					rem_q <= diff;
					day_q <= day_q + 5'd1;
				end
			end
			ST_HOUR: begin
				if (ge) begin
					rem_q  <= diff;
					hour_q <= hour_q + 5'd1;
				end
			end
			ST_MINUTE: begin
				if (ge) begin
					rem_q <= diff;
					min_q <= min_q + 6'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= {2'b00, rem_q[5:0], min_q, hour_q, day_q + 5'd1,
				mon_q + 4'd1, year_q};
		end
	end

	// A finished conversion leaves less than one minute in the remainder.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (rem_q < esc_pkg::SECS_PER_MIN))
		else $error("remainder not below one minute at the end of a conversion");

	// The month walk never passes December.
	assert property (@(posedge clk) disable iff (!arst_n)
		mon_q <= esc_pkg::LAST_MONTH)
		else $error("month index past December");

	// Hours are fully stripped before the minute step.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MINUTE) |-> (hour_q < 5'd24 && rem_q < esc_pkg::SECS_PER_HOUR))
		else $error("hour step left a full hour");

	// A held result is not overwritten while the sink stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> $stable(out_data_q))
		else $error("pending result changed under stall");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

package tb_calendar_pkg;

	localparam int unsigned FIRST_YEAR   = 1970;
	localparam int unsigned DAY_SECS     = 86400;
	localparam int unsigned HOUR_SECS    = 3600;
	localparam int unsigned MIN_SECS     = 60;
	localparam int unsigned MAX_REPORTS  = 50;

	// One calendar result as it sits on the master data bus, year in the lowest bits.
	typedef struct packed {
		logic [1:0]  pad;
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
	} calendar_t;

	// Month length in days; every fourth year is a leap year, 2100 included.
	function automatic int unsigned days_in_month(int unsigned yr, int unsigned mo);
		case (mo)
			2: return ((yr % 4) == 0) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	// Calendar date and time of day for a seconds count since the start of 1970.
	function automatic calendar_t calendar_of(logic [31:0] secs);
		longint unsigned left;
		longint unsigned span;
		int unsigned yr;
		int unsigned mo;
		calendar_t cal;
		left = secs;
		yr = FIRST_YEAR;
		mo = 1;
		// Strip whole years, then whole months, capping the walk at December.
		forever begin
			span = ((yr % 4) == 0) ? 366 * DAY_SECS : 365 * DAY_SECS;
			if (left < span)
				break;
			left -= span;
			yr++;
		end
		while (mo < 12) begin
			span = days_in_month(yr, mo) * DAY_SECS;
			if (left < span)
				break;
			left -= span;
			mo++;
		end
		cal.pad = 2'b00;
		cal.year = 12'(yr);
		cal.month = 4'(mo);
		cal.day = 5'(left / DAY_SECS + 1);
		left = left % DAY_SECS;
		cal.hour = 5'(left / HOUR_SECS);
		left = left % HOUR_SECS;
		cal.minute = 6'(left / MIN_SECS);
		cal.second = 6'(left % MIN_SECS);
		return cal;
	endfunction

	// Seconds count of a given calendar moment, used to aim requests at boundaries.
	function automatic logic [31:0] epoch_of(int unsigned yr, int unsigned mo, int unsigned d,
			int unsigned hh, int unsigned mm, int unsigned ss);
		longint unsigned total;
		total = 0;
		for (int unsigned y = FIRST_YEAR; y < yr; y++)
			total += ((y % 4) == 0) ? 366 * DAY_SECS : 365 * DAY_SECS;
		for (int unsigned m = 1; m < mo; m++)
			total += days_in_month(yr, m) * DAY_SECS;
		total += (d - 1) * DAY_SECS + hh * HOUR_SECS + mm * MIN_SECS + ss;
		return total[31:0];
	endfunction

	// Keeps the calendar results still owed by the block, oldest first.
	class calendar_scoreboard;
		calendar_t owed_q[$];
		int unsigned errors = 0;
		int unsigned requests = 0;
		int unsigned results = 0;

		function void note_request(logic [31:0] secs);
			owed_q.push_back(calendar_of(secs));
			requests++;
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(logic [39:0] data);
			calendar_t want;
			calendar_t got;
			got = data;
			if (owed_q.size() == 0) begin
				errors++;
				$display("%0t: result %h arrived with no request outstanding", $time, data);
				return;
			end
			want = owed_q.pop_front();
			results++;
			compare_field("year", want.year, got.year);
			compare_field("month", want.month, got.month);
			compare_field("day", want.day, got.day);
			compare_field("hour", want.hour, got.hour);
			compare_field("minute", want.minute, got.minute);
			compare_field("second", want.second, got.second);
			compare_field("padding", want.pad, got.pad);
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction
	endclass

endpackage

module tb;

	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned DRAIN_CYCLES = 300;
	localparam int unsigned PHASE_ITEMS  = 142;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // epoch_seconds[31:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // year, month, day, hour, minute, second, zero

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned cycles = 0;

	tb_calendar_pkg::calendar_scoreboard board = new();

	epoch_seconds_to_calendar_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results owed", cycles, board.pending());
			$display("epoch_seconds_to_calendar_core regression: fail");
			$finish;
		end
	end

	// Result side: check each accepted result, then pick the next ready level.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			board.check_result(m_tdata);
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Offer one request, idling at random first, and return once it is taken.
	task automatic send_request(input logic [31:0] secs);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= secs;
		do
			@(posedge clk);
		while (!s_tready);
		board.note_request(secs);
	endtask

	// Random seconds count: real dates and raw words, some month ends and the top.
	function automatic logic [31:0] random_epoch();
		int unsigned pick;
		int unsigned yr;
		int unsigned mo;
		pick = $urandom_range(0, 9);
		yr = $urandom_range(1970, 2105);
		mo = $urandom_range(1, 12);
		if (pick < 4)
			return $urandom;
		if (pick < 8)
			return tb_calendar_pkg::epoch_of(yr, mo,
				$urandom_range(1, tb_calendar_pkg::days_in_month(yr, mo)),
				$urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
		if (pick == 8)
			return tb_calendar_pkg::epoch_of(yr, mo, tb_calendar_pkg::days_in_month(yr, mo),
				23, 59, 59) + $urandom_range(0, 2);
		return $urandom_range(tb_calendar_pkg::epoch_of(2106, 1, 1, 0, 0, 0), 32'hFFFF_FFFF);
	endfunction

	initial begin
		logic [31:0] corner_q[$];

		// Day, hour and minute rollovers, leap and common February, century and both ends.
		corner_q = '{32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
			tb_calendar_pkg::epoch_of(1970, 12, 31, 23, 59, 59),
			tb_calendar_pkg::epoch_of(1971, 1, 1, 0, 0, 0),
			tb_calendar_pkg::epoch_of(1972, 2, 28, 23, 59, 59),
			tb_calendar_pkg::epoch_of(1972, 2, 29, 0, 0, 0),
			tb_calendar_pkg::epoch_of(1972, 2, 29, 23, 59, 59),
			tb_calendar_pkg::epoch_of(1972, 3, 1, 0, 0, 0),
			tb_calendar_pkg::epoch_of(1973, 2, 28, 23, 59, 59),
			tb_calendar_pkg::epoch_of(1973, 3, 1, 0, 0, 0),
			tb_calendar_pkg::epoch_of(1972, 12, 31, 23, 59, 59),
			tb_calendar_pkg::epoch_of(1999, 12, 31, 23, 59, 59),
			tb_calendar_pkg::epoch_of(2000, 1, 1, 0, 0, 0), 32'h7FFF_FFFF, 32'h8000_0000,
			tb_calendar_pkg::epoch_of(2100, 2, 29, 12, 0, 0),
			tb_calendar_pkg::epoch_of(2100, 12, 31, 23, 59, 59),
			tb_calendar_pkg::epoch_of(2106, 1, 1, 0, 0, 0), 32'hFFFF_FFFE, 32'hFFFF_FFFF};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 14;
		recv_idle_pct = 56;
		foreach (corner_q[i])
			send_request(corner_q[i]);

		// Three pressure phases: slow receiver, slow sender, then full rate.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 56 : 0;
			recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 14 : 0;
			repeat (PHASE_ITEMS)
				send_request(random_epoch());
		end
		s_tvalid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d seconds counts to calendar dates and checked %0d results,",
			board.requests, board.results);
		$display("over both range ends, leap boundaries and three handshake pressure phases.");
		if (board.errors == 0) begin
			$display("epoch_seconds_to_calendar_core regression: pass");
		end else begin
			$display("epoch_seconds_to_calendar_core regression: fail");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/esc_pkg.sv
hw/rtl/epoch_seconds_to_calendar_core.sv
bench/tb.sv
